FILE: src/mcsl_pkg.sv
// ----------------------------------------------------------------------------
// mcsl_pkg
// Types and constants shared by the motor current and slew limiter.
// ----------------------------------------------------------------------------
package mcsl_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [2:0] RegSenseThreshold = 3'd0;
  localparam logic [2:0] RegClampLimit     = 3'd1;
  localparam logic [2:0] RegRetryTicks     = 3'd2;
  localparam logic [2:0] RegDecayStep      = 3'd3;
  localparam logic [2:0] RegSpikeStep      = 3'd4;
  localparam logic [2:0] RegSpikeLimit     = 3'd5;
  localparam logic [2:0] RegMaxSlew        = 3'd6;
  localparam logic [2:0] RegAntiphaseMode  = 3'd7;

  localparam logic [8:0]  SenseThresholdRst = 9'd68;
  localparam logic [10:0] ClampLimitRst     = 11'd512;
  localparam logic [15:0] RetryTicksRst     = 16'd1024;
  localparam logic [7:0]  DecayStepRst      = 8'd1;
  localparam logic [7:0]  SpikeStepRst      = 8'd1;
  localparam logic [15:0] SpikeLimitRst     = 16'd1024;
  localparam logic [11:0] MaxSlewRst        = 12'd4;
  localparam logic        AntiphaseModeRst  = 1'b0;

  localparam logic [10:0] MidScale    = 11'h200;
  localparam logic [16:0] LevelCap    = 17'h0FF00;
  localparam logic [12:0] DutyOffset  = 13'h0800;
  localparam logic [11:0] DriveMinRaw = 12'h800;
  localparam logic [11:0] DriveMinSat = 12'h801;

  typedef struct packed {
    logic [9:0]         current_sample;
    logic signed [11:0] requested_drive;
    logic               drive_enable;
  } in_t;

  typedef struct packed {
    logic signed [11:0] limited_drive;
    logic [10:0]        duty;
    logic               forward;
    logic               error_light;
    logic               clamping;
    logic [15:0]        spike_level;
  } out_t;

endpackage

FILE: src/mcsl_stream_if.sv
// ----------------------------------------------------------------------------
// mcsl_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mcsl_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

FILE: src/motor_current_and_slew_limiter.sv
// ----------------------------------------------------------------------------
// motor_current_and_slew_limiter
// Overcurrent spike tracking, current clamp with retry, slew limit and PWM duty.
//
// Usage: one transaction on in_if is one control tick (current sample,
// requested signed drive, enable). Each tick yields exactly one transaction
// on out_if with the limited drive, PWM duty, direction, error and clamp
// flags and the spike level after the tick.
// Structure: one input register, then the tick logic feeds the result
// register, which drives out_if. A new tick is accepted every cycle while
// out_if takes results; throughput is then one tick per cycle, set by the
// single state update between the two registers.
// When out_if stalls, the result register holds and the input register
// holds one more tick; in_if.ready drops only once both are full.
// Reset clears spike level, clamp, error, retry counter, previous drive and
// both valid flags, and loads the default register values. Registers are
// written over the APB port at byte address 4*index and should change only
// while no tick is in flight.
// ----------------------------------------------------------------------------
module motor_current_and_slew_limiter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mcsl_stream_if.sink               in_if,
  mcsl_stream_if.source             out_if,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mcsl_pkg::AddrW-1:0] paddr,
  input  logic [mcsl_pkg::DataW-1:0] pwdata,
  output logic [mcsl_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  import mcsl_pkg::*;

  // configuration registers
  logic [8:0]  sense_threshold_q;
  logic [10:0] clamp_limit_q;
  logic [15:0] retry_ticks_q;
  logic [7:0]  decay_step_q;
  logic [7:0]  spike_step_q;
  logic [15:0] spike_limit_q;
  logic [11:0] max_slew_q;
  logic        antiphase_mode_q;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_threshold_q <= SenseThresholdRst;
      clamp_limit_q     <= ClampLimitRst;
      retry_ticks_q     <= RetryTicksRst;
      decay_step_q      <= DecayStepRst;
      spike_step_q      <= SpikeStepRst;
      spike_limit_q     <= SpikeLimitRst;
      max_slew_q        <= MaxSlewRst;
      antiphase_mode_q  <= AntiphaseModeRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegSenseThreshold: sense_threshold_q <= pwdata[8:0];
        RegClampLimit:     clamp_limit_q     <= pwdata[10:0];
        RegRetryTicks:     retry_ticks_q     <= pwdata[15:0];
        RegDecayStep:      decay_step_q      <= pwdata[7:0];
        RegSpikeStep:      spike_step_q      <= pwdata[7:0];
        RegSpikeLimit:     spike_limit_q     <= pwdata[15:0];
        RegMaxSlew:        max_slew_q        <= pwdata[11:0];
        RegAntiphaseMode:  antiphase_mode_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegSenseThreshold: prdata = DataW'(sense_threshold_q);
      RegClampLimit:     prdata = DataW'(clamp_limit_q);
      RegRetryTicks:     prdata = DataW'(retry_ticks_q);
      RegDecayStep:      prdata = DataW'(decay_step_q);
      RegSpikeStep:      prdata = DataW'(spike_step_q);
      RegSpikeLimit:     prdata = DataW'(spike_limit_q);
      RegMaxSlew:        prdata = DataW'(max_slew_q);
      RegAntiphaseMode:  prdata = DataW'(antiphase_mode_q);
      default:           prdata = '0;
    endcase
  end

  // handshake
  logic s1_valid_q;
  in_t  s1_q;
  logic out_valid_q;
  out_t out_q;
  logic out_adv;
  logic in_acc;
  logic tick;

  assign out_adv     = ~out_valid_q | out_if.ready;
  assign in_if.ready = ~s1_valid_q | out_adv;
  assign in_acc      = in_if.valid & in_if.ready;
  assign tick        = s1_valid_q & out_adv;

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_if.payload;
    end
  end

  // tick state
  logic [15:0]        acc_q, acc_d;
  logic               clamp_q, clamp_d;
  logic               err_q, err_d;
  logic [15:0]        cnt_q, cnt_d;
  logic signed [11:0] prev_q, prev_d;

  logic [10:0]        hi_bound, lo_bound, sample_ext;
  logic               over;
  logic [16:0]        acc_sum;
  logic               en;
  logic [11:0]        req_sat;
  logic signed [13:0] req_ext, lim, clipped, diff, slew, step, next_v;
  logic signed [11:0] drv;
  logic [12:0]        anti_sum;
  logic [11:0]        mag;
  out_t               res;

  always_comb begin
    en         = s1_q.drive_enable;
    sample_ext = {1'b0, s1_q.current_sample};
    hi_bound   = MidScale + {2'b00, sense_threshold_q};
    lo_bound   = MidScale - {2'b00, sense_threshold_q};
    over       = (sample_ext > hi_bound) || (sample_ext < lo_bound);

    // spike level
    acc_sum = {1'b0, acc_q} + {9'd0, spike_step_q};
    if (over) begin
      acc_d = (acc_sum > LevelCap) ? LevelCap[15:0] : acc_sum[15:0];
    end else if (acc_q <= {8'd0, decay_step_q}) begin
      acc_d = '0;
    end else begin
      acc_d = acc_q - {8'd0, decay_step_q};
    end

    // retry and clamp
    clamp_d = clamp_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    if (en) begin
      if (cnt_q != '0) begin
        if (cnt_q == retry_ticks_q) begin
          clamp_d = 1'b0;
          err_d   = 1'b0;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 16'd1;
        end
      end
      if (acc_d > spike_limit_q) begin
        clamp_d = 1'b1;
        err_d   = 1'b1;
        if (cnt_d == '0) begin
          cnt_d = 16'd1;
        end
      end
    end

    // current clamp
    req_sat = (s1_q.requested_drive == DriveMinRaw) ? DriveMinSat : s1_q.requested_drive;
    req_ext = 14'(signed'(req_sat));
    lim     = signed'({3'b000, clamp_limit_q});
    clipped = req_ext;
    if (clamp_d) begin
      if (clipped < -lim) begin
        clipped = -lim;
      end
      if (clipped > lim) begin
        clipped = lim;
      end
    end

    // slew limit
    diff = clipped - 14'(prev_q);
    slew = signed'({2'b00, max_slew_q});
    step = diff;
    if (step < -slew) begin
      step = -slew;
    end
    if (step > slew) begin
      step = slew;
    end
    next_v = 14'(prev_q) + step;

    if (en) begin
      drv    = next_v[11:0];
      prev_d = next_v[11:0];
    end else begin
      drv    = '0;
      prev_d = '0;
    end

    // duty
    anti_sum = 13'(drv) + DutyOffset;
    mag      = drv[11] ? 12'(-drv) : drv;

    res.limited_drive = drv;
    res.forward       = en & ~drv[11];
    res.error_light   = err_d;
    res.clamping      = clamp_d;
    res.spike_level   = acc_d;
    if (!en) begin
      res.duty = '0;
    end else if (antiphase_mode_q) begin
      res.duty = anti_sum[11:1];
    end else begin
      res.duty = mag[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      clamp_q <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
      prev_q  <= '0;
    end else if (tick) begin
      acc_q   <= acc_d;
      clamp_q <= clamp_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= res;
    end
  end

endmodule

FILE: sim/motor_current_and_slew_limiter_tb.sv
// ----------------------------------------------------------------------------
// motor_current_and_slew_limiter_tb
// Self-checking bench for the motor current and slew limiter. A directed
// table of ticks at the default settings comes first, then phases of random
// ticks under extreme and random register settings written over APB. Every
// output transaction is checked field by field against the typed row's
// values or a tick-accurate model of spike tracking, clamp/retry, slew
// limiting and PWM duty, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module motor_current_and_slew_limiter_tb;
  import mcsl_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } tick_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  mcsl_stream_if #(.payload_t(in_t))  tick_if ();
  mcsl_stream_if #(.payload_t(out_t)) result_if ();

  motor_current_and_slew_limiter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (tick_if),
    .out_if  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  int          thr_cfg;
  int          clamp_cfg;
  logic [15:0] retry_cfg;
  int          decay_cfg;
  int          spike_cfg;
  int          limit_cfg;
  int          slew_cfg;
  bit          anti_cfg;

  // tick state
  int          level;
  bit          clamp_on;
  bit          err_on;
  logic [15:0] retry_cnt;
  int          prev_drive;

  out_t        pending_results[$];
  int          mismatches = 0;
  int          gap_odds = 0;

  tick_row_t directed_rows [16] = '{
    '{'{10'd512,  12'sd0,     1'b1}, 1'b1, '{12'sd0,  11'd0, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{'{10'd0,    12'sd2047,  1'b1}, 1'b1, '{12'sd4,  11'd4, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{'{10'd1023, DriveMinRaw, 1'b0}, 1'b1, '{12'sd0, 11'd0, 1'b0, 1'b0, 1'b0, 16'd2}},
    '{'{10'd580,  DriveMinRaw, 1'b1}, 1'b1, '{-12'sd4, 11'd4, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{10'd444,  12'sd2047,  1'b1}, 1'b1, '{12'sd0,  11'd0, 1'b1, 1'b0, 1'b0, 16'd0}},
    '{'{10'd581,  12'sd0,     1'b1}, 1'b1, '{12'sd0,  11'd0, 1'b1, 1'b0, 1'b0, 16'd1}},
    '{'{10'd443,  -12'sd1,    1'b1}, 1'b0, '0},
    '{'{10'd1023, 12'sd2047,  1'b1}, 1'b0, '0},
    '{'{10'd0,    -12'sd2047, 1'b1}, 1'b0, '0},
    '{'{10'd512,  DriveMinRaw, 1'b1}, 1'b0, '0},
    '{'{10'd700,  12'sd100,   1'b0}, 1'b0, '0},
    '{'{10'd300,  12'sd2047,  1'b1}, 1'b0, '0},
    '{'{10'd1,    -12'sd3,    1'b1}, 1'b0, '0},
    '{'{10'd1022, 12'sd5,     1'b1}, 1'b0, '0},
    '{'{10'd511,  12'sd2046,  1'b0}, 1'b0, '0},
    '{'{10'd513,  -12'sd2046, 1'b1}, 1'b0, '0}
  };

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic limiter_step(input in_t t, output out_t r);
    int          req;
    int          v;
    int          d;
    int unsigned sum;
    int          duty_v;
    bit          over;
    req = t.requested_drive;
    if (req < -2047) req = -2047;
    over = (int'(t.current_sample) > int'(MidScale) + thr_cfg) ||
           (int'(t.current_sample) < int'(MidScale) - thr_cfg);
    if (over) begin
      sum = level + spike_cfg;
      level = (sum > int'(LevelCap)) ? int'(LevelCap) : sum;
    end else if (level <= decay_cfg) begin
      level = 0;
    end else begin
      level = level - decay_cfg;
    end
    v = 0;
    duty_v = 0;
    if (!t.drive_enable) begin
      prev_drive = 0;
    end else begin
      if (retry_cnt != 16'd0) begin
        if (retry_cnt == retry_cfg) begin
          clamp_on = 1'b0;
          retry_cnt = 16'd0;
          err_on = 1'b0;
        end else begin
          retry_cnt = retry_cnt + 16'd1;
        end
      end
      if (level > limit_cfg) begin
        err_on = 1'b1;
        clamp_on = 1'b1;
        if (retry_cnt == 16'd0) retry_cnt = 16'd1;
      end
      v = req;
      if (clamp_on) v = clip(v, -clamp_cfg, clamp_cfg);
      d = clip(v - prev_drive, -slew_cfg, slew_cfg);
      prev_drive = clip(prev_drive + d, -2047, 2047);
      v = prev_drive;
      duty_v = anti_cfg ? (v + int'(DutyOffset)) / 2 : (v < 0 ? -v : v);
    end
    r.limited_drive = 12'(v);
    r.duty          = 11'(duty_v);
    r.forward       = t.drive_enable && v >= 0;
    r.error_light   = err_on;
    r.clamping      = clamp_on;
    r.spike_level   = 16'(level);
  endtask

  task automatic set_reg(input logic [2:0] idx, input int unsigned val);
    case (idx)
      RegSenseThreshold: thr_cfg   = val & 'h1FF;
      RegClampLimit:     clamp_cfg = val & 'h7FF;
      RegRetryTicks:     retry_cfg = 16'(val);
      RegDecayStep:      decay_cfg = val & 'hFF;
      RegSpikeStep:      spike_cfg = val & 'hFF;
      RegSpikeLimit:     limit_cfg = val & 'hFFFF;
      RegMaxSlew:        slew_cfg  = val & 'hFFF;
      RegAntiphaseMode:  anti_cfg  = val[0];
      default: ;
    endcase
  endtask

  // leaves psel and penable high, the caller closes the last access
  task automatic apb_write(input logic [2:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    set_reg(idx, val);
  endtask

  task automatic send_tick(input in_t item, input bit typed, input out_t want);
    out_t pred;
    if (gap_odds != 0 && $urandom_range(1, 10) <= gap_odds) begin
      tick_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    tick_if.valid   <= 1'b1;
    tick_if.payload <= item;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    limiter_step(item, pred);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    tick_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic flag(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transaction, drive %0d spike level %0d",
                 $time, got.limited_drive, got.spike_level);
      end else begin
        want = pending_results.pop_front();
        if (got.limited_drive !== want.limited_drive)
          flag("limited_drive", want.limited_drive, got.limited_drive);
        if (got.duty !== want.duty) flag("duty", want.duty, got.duty);
        if (got.forward !== want.forward) flag("forward", want.forward, got.forward);
        if (got.error_light !== want.error_light)
          flag("error_light", want.error_light, got.error_light);
        if (got.clamping !== want.clamping) flag("clamping", want.clamping, got.clamping);
        if (got.spike_level !== want.spike_level)
          flag("spike_level", want.spike_level, got.spike_level);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && gap_odds != 0 && $urandom_range(1, 12) <= gap_odds)
        hold = $urandom_range(1, 8);
      if (hold > 0) begin
        result_if.ready <= 1'b0;
        hold--;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned cv [NumRegs];
    in_t         item;
    int          edge_pt;
    rst_ni          <= 1'b0;
    tick_if.valid   <= 1'b0;
    tick_if.payload <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    thr_cfg   = SenseThresholdRst;
    clamp_cfg = ClampLimitRst;
    retry_cfg = RetryTicksRst;
    decay_cfg = DecayStepRst;
    spike_cfg = SpikeStepRst;
    limit_cfg = SpikeLimitRst;
    slew_cfg  = MaxSlewRst;
    anti_cfg  = AntiphaseModeRst;
    level      = 0;
    clamp_on   = 1'b0;
    err_on     = 1'b0;
    retry_cnt  = 16'd0;
    prev_drive = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_odds = 2;
    foreach (directed_rows[i])
      send_tick(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 1; phase <= 12; phase++) begin
      drain();
      case (phase)
        1: begin
          cv[RegSenseThreshold] = 0;
          cv[RegClampLimit]     = 0;
          cv[RegRetryTicks]     = 1;
          cv[RegDecayStep]      = 0;
          cv[RegSpikeStep]      = 0;
          cv[RegSpikeLimit]     = 0;
          cv[RegMaxSlew]        = 0;
          cv[RegAntiphaseMode]  = 0;
        end
        2: begin
          cv[RegSenseThreshold] = 511;
          cv[RegClampLimit]     = 2047;
          cv[RegRetryTicks]     = 65535;
          cv[RegDecayStep]      = 255;
          cv[RegSpikeStep]      = 255;
          cv[RegSpikeLimit]     = 65535;
          cv[RegMaxSlew]        = 4095;
          cv[RegAntiphaseMode]  = 1;
        end
        3: begin
          // zero retry count holds the clamp
          cv[RegSenseThreshold] = 20;
          cv[RegClampLimit]     = $urandom_range(0, 2047);
          cv[RegRetryTicks]     = 0;
          cv[RegDecayStep]      = 1;
          cv[RegSpikeStep]      = 255;
          cv[RegSpikeLimit]     = 50;
          cv[RegMaxSlew]        = 4095;
          cv[RegAntiphaseMode]  = $urandom_range(0, 1);
        end
        4: begin
          cv[RegSenseThreshold] = $urandom_range(0, 511);
          cv[RegClampLimit]     = 0;
          cv[RegRetryTicks]     = 1;
          cv[RegDecayStep]      = 255;
          cv[RegSpikeStep]      = 200;
          cv[RegSpikeLimit]     = 0;
          cv[RegMaxSlew]        = $urandom_range(0, 4095);
          cv[RegAntiphaseMode]  = 1;
        end
        default: begin
          cv[RegSenseThreshold] = $urandom_range(0, 3) == 0 ? 511 * $urandom_range(0, 1)
                                                            : $urandom_range(0, 200);
          cv[RegClampLimit]     = $urandom_range(0, 2047);
          cv[RegRetryTicks]     = $urandom_range(0, 5) == 0 ? $urandom_range(1, 65535)
                                                            : $urandom_range(1, 40);
          cv[RegDecayStep]      = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                       : $urandom_range(0, 255);
          cv[RegSpikeStep]      = $urandom_range(0, 255);
          cv[RegSpikeLimit]     = $urandom_range(0, 5) == 0 ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 400);
          cv[RegMaxSlew]        = $urandom_range(0, 1) ? $urandom_range(0, 64)
                                                       : $urandom_range(0, 4095);
          cv[RegAntiphaseMode]  = $urandom_range(0, 1);
        end
      endcase
      for (int r = 0; r < NumRegs; r++) apb_write(3'(r), cv[r]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      gap_odds = (phase == 12) ? 0 : $urandom_range(0, 3);

      for (int n = 0; n < 125; n++) begin
        case ($urandom_range(0, 3))
          0: item.current_sample = 10'(int'(MidScale) - thr_cfg +
                                       $urandom_range(0, 2 * thr_cfg));
          1: item.current_sample = 10'($urandom_range(0, 1023));
          2: begin
            case ($urandom_range(0, 3))
              0: edge_pt = int'(MidScale) - thr_cfg - 1;
              1: edge_pt = int'(MidScale) - thr_cfg;
              2: edge_pt = int'(MidScale) + thr_cfg;
              default: edge_pt = int'(MidScale) + thr_cfg + 1;
            endcase
            item.current_sample = 10'(clip(edge_pt, 0, 1023));
          end
          default: item.current_sample = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        endcase
        case ($urandom_range(0, 7))
          0: item.requested_drive = DriveMinRaw;
          1: item.requested_drive = 12'sd2047;
          2: item.requested_drive = -12'sd2047;
          3: item.requested_drive = 12'($urandom_range(0, 40) - 20);
          default: item.requested_drive = 12'($urandom);
        endcase
        item.drive_enable = $urandom_range(0, 7) != 0;
        send_tick(item, 1'b0, '0);
      end
    end
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
